// ===== src/mf3_pkg.sv =====
// ----------------------------------------------------------------------------
// mf3_pkg
// Shared widths, types and limits of the 3x3 median filter.
// ----------------------------------------------------------------------------
package mf3_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int PIX_W     = 8;
    localparam int DIM_W     = 11;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = $clog2(MAX_HEIGHT);
    localparam int CNT_W     = COL_W + ROW_W;
    localparam int WIN_SIZE  = 9;
    localparam int CFG_IDX_W = 1;

    typedef logic [PIX_W-1:0] pix_t;

    // row-major 3x3 window, element 0 is the oldest pixel of the top row
    typedef logic [WIN_SIZE-1:0][PIX_W-1:0] win_t;

    typedef struct packed {
        win_t win;
        pix_t bypass;
        logic interior;
        logic frame_end;
    } med_in_t;

endpackage

// ===== src/mf3_median.sv =====
// ----------------------------------------------------------------------------
// mf3_median
// Three-stage median-of-nine pipeline with output register and backpressure.
// ----------------------------------------------------------------------------
module mf3_median (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  mf3_pkg::med_in_t in_data,
    output logic             m_valid,
    input  logic             m_ready,
    output mf3_pkg::pix_t    m_pixel,
    output logic             m_last
);
    import mf3_pkg::*;

    typedef logic [2:0][PIX_W-1:0] trio_t;

    typedef struct packed {
        pix_t max_lo;
        pix_t med_mid;
        pix_t min_hi;
        pix_t bypass;
        logic interior;
        logic frame_end;
    } cand_t;

    function automatic pix_t min2(input pix_t a, input pix_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic pix_t max2(input pix_t a, input pix_t b);
        return (a < b) ? b : a;
    endfunction

    function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    function automatic trio_t sort3(input pix_t a, input pix_t b, input pix_t c);
        trio_t r;
        r[0] = min2(min2(a, b), c);
        r[1] = med3(a, b, c);
        r[2] = max2(max2(a, b), c);
        return r;
    endfunction

    logic    a_valid_reg;
    logic    b_valid_reg;
    logic    out_valid_reg;
    med_in_t a_reg;
    med_in_t a_next;
    cand_t   b_reg;
    cand_t   b_next;
    pix_t    pix_out_reg;
    pix_t    pix_out_next;
    logic    last_out_reg;
    logic    a_rdy;
    logic    b_rdy;
    logic    out_rdy;

    assign out_rdy  = !out_valid_reg || m_ready;
    assign b_rdy    = !b_valid_reg || out_rdy;
    assign a_rdy    = !a_valid_reg || b_rdy;
    assign in_ready = a_rdy;

    // sort each row
    always_comb begin
        trio_t t;
        a_next = in_data;
        for (int r = 0; r < 3; r++) begin
            t = sort3(in_data.win[3*r], in_data.win[3*r+1], in_data.win[3*r+2]);
            a_next.win[3*r]   = t[0];
            a_next.win[3*r+1] = t[1];
            a_next.win[3*r+2] = t[2];
        end
    end

    // max of minima, median of middles, min of maxima
    always_comb begin
        b_next.max_lo    = max2(max2(a_reg.win[0], a_reg.win[3]), a_reg.win[6]);
        b_next.med_mid   = med3(a_reg.win[1], a_reg.win[4], a_reg.win[7]);
        b_next.min_hi    = min2(min2(a_reg.win[2], a_reg.win[5]), a_reg.win[8]);
        b_next.bypass    = a_reg.bypass;
        b_next.interior  = a_reg.interior;
        b_next.frame_end = a_reg.frame_end;
    end

    always_comb begin
        if (b_reg.interior) begin
            pix_out_next = med3(b_reg.max_lo, b_reg.med_mid, b_reg.min_hi);
        end else begin
            pix_out_next = b_reg.bypass;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (a_rdy) begin
                a_valid_reg <= in_valid;
            end
            if (b_rdy) begin
                b_valid_reg <= a_valid_reg;
            end
            if (out_rdy) begin
                out_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (a_rdy && in_valid) begin
            a_reg <= a_next;
        end
        if (b_rdy && a_valid_reg) begin
            b_reg <= b_next;
        end
        if (out_rdy && b_valid_reg) begin
            pix_out_reg  <= pix_out_next;
            last_out_reg <= b_reg.frame_end;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_pixel = pix_out_reg;
    assign m_last  = last_out_reg;

endmodule

// ===== src/median_filter_3x3_unit.sv =====
// ----------------------------------------------------------------------------
// median_filter_3x3_unit
// 3x3 median filter over an 8-bit raster stream with two line memories.
// ----------------------------------------------------------------------------
// Pixels enter on the s_ stream, one per transfer, in raster order; s_tuser
// high marks a drain transfer that emits one owed output after the last
// pixel of a frame. Results leave on the m_ stream; m_tlast marks the last
// pixel of the frame. Frame width and height are to be written through the
// cfg_ channel (index 0 width, index 1 height) only while the block is idle;
// the block itself does not enforce this. A frame's output lags its input by
// width+1 pixels; interior pixels become the median of their neighbourhood,
// border pixels and frames smaller than three in either direction pass through.
// Throughput is one transfer per cycle while the output is not stalled and the
// line memories are not being cleared. An accepted transfer passes the line
// memory read and window update, the median network, then the output register.
// A line entry read in the same cycle as it is written is forwarded from the
// write-back path.
// After reset all 1024 entries of both line memories are cleared, during which
// s_tready stays low; cfg writes are taken throughout.
// When m_tready is low the pipeline fills its empty stages and then holds
// s_tready low until the output transfer completes.
// ----------------------------------------------------------------------------
module median_filter_3x3_unit (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [mf3_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mf3_pkg::DIM_W-1:0]    cfg_data,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  mf3_pkg::pix_t                s_tdata,   // [7:0] pixel
    input  logic                         s_tuser,   // [0] mode
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output mf3_pkg::pix_t                m_tdata,   // [7:0] pixel_out
    output logic                         m_tlast
);
    import mf3_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;
    localparam logic                 MODE_DRAIN       = 1'b1;
    localparam logic [DIM_W-1:0]     RESET_WIDTH      = DIM_W'(640);
    localparam logic [DIM_W-1:0]     RESET_HEIGHT     = DIM_W'(480);

    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] lim);
        if (v == '0) begin
            return DIM_W'(1);
        end else if (v > lim) begin
            return lim;
        end
        return v;
    endfunction

    // configuration
    logic [DIM_W-1:0] w_reg;
    logic [DIM_W-1:0] h_reg;

    // position counters
    logic [COL_W-1:0] in_col_reg,  in_col_next;
    logic [ROW_W-1:0] in_row_reg,  in_row_next;
    logic [CNT_W-1:0] in_cnt_reg,  in_cnt_next;
    logic [COL_W-1:0] out_col_reg, out_col_next;
    logic [ROW_W-1:0] out_row_reg, out_row_next;
    logic             drain_reg,   drain_next;

    // stage 0 decode
    logic             accept;
    logic             is_drain;
    logic [COL_W-1:0] ocol;
    logic [ROW_W-1:0] orow;
    logic             last_col;
    logic             last_row;
    logic             frame_end;
    logic             interior;
    logic             pix_emit;
    logic             emit;
    logic             mem_src;
    logic [COL_W-1:0] rd_addr;
    logic             v1_next;
    logic             hit_next;

    // stage 1
    logic             v1_reg;
    logic             s1_pix_reg;
    pix_t             s1_p_reg;
    logic             s1_emit_reg;
    logic             s1_int_reg;
    logic             s1_end_reg;
    logic             s1_mem_reg;
    logic [COL_W-1:0] s1_addr_reg;
    logic             fwd_hit_reg;
    pix_t             fwd_up_reg;
    pix_t             fwd_lo_reg;
    pix_t             up_eff;
    pix_t             lo_eff;
    win_t             window_reg, window_next;
    logic             fire1;
    med_in_t          med_in;
    logic             med_valid;
    logic             med_ready;

    // line memories
    pix_t             upper_mem [MAX_WIDTH];
    pix_t             lower_mem [MAX_WIDTH];
    pix_t             up_rd_reg;
    pix_t             lo_rd_reg;
    logic             mem_we;
    logic [COL_W-1:0] mem_wa;
    pix_t             up_wd;
    pix_t             lo_wd;
    logic             clr_busy_reg;
    logic [COL_W-1:0] clr_addr_reg;

    assign cfg_ready = 1'b1;

    // stage 1: window update and write-back
    always_comb begin
        up_eff = fwd_hit_reg ? fwd_up_reg : up_rd_reg;
        lo_eff = fwd_hit_reg ? fwd_lo_reg : lo_rd_reg;

        window_next = window_reg;
        for (int r = 0; r < 3; r++) begin
            window_next[3*r]   = window_reg[3*r+1];
            window_next[3*r+1] = window_reg[3*r+2];
        end
        window_next[2] = up_eff;
        window_next[5] = lo_eff;
        window_next[8] = s1_p_reg;

        med_in.win       = window_next;
        med_in.bypass    = (!s1_pix_reg && s1_mem_reg) ? lo_eff : window_reg[5];
        med_in.interior  = s1_int_reg;
        med_in.frame_end = s1_end_reg;

        med_valid = v1_reg && s1_emit_reg;
        fire1     = v1_reg && (!s1_emit_reg || med_ready);

        mem_we = clr_busy_reg || (fire1 && s1_pix_reg);
        mem_wa = clr_busy_reg ? clr_addr_reg : s1_addr_reg;
        up_wd  = clr_busy_reg ? '0 : lo_eff;
        lo_wd  = clr_busy_reg ? '0 : s1_p_reg;
    end

    assign s_tready = !clr_busy_reg && (!v1_reg || fire1);

    // stage 0: position tracking and output decisions
    always_comb begin
        accept   = s_tvalid && s_tready;
        is_drain = (s_tuser == MODE_DRAIN);

        // a pixel arriving while draining starts a new frame
        ocol = (drain_reg && !is_drain) ? '0 : out_col_reg;
        orow = (drain_reg && !is_drain) ? '0 : out_row_reg;

        last_col  = (DIM_W'(ocol) + DIM_W'(1)) >= w_reg;
        last_row  = (DIM_W'(orow) + DIM_W'(1)) >= h_reg;
        frame_end = last_col && last_row;
        interior  = !is_drain && (w_reg >= DIM_W'(3)) && (h_reg >= DIM_W'(3)) &&
                    (orow != '0) && ((DIM_W'(orow) + DIM_W'(2)) <= h_reg) &&
                    (ocol != '0) && ((DIM_W'(ocol) + DIM_W'(2)) <= w_reg);
        pix_emit  = in_cnt_reg >= (CNT_W'(w_reg) + CNT_W'(1));
        emit      = is_drain ? drain_reg : pix_emit;
        mem_src   = (DIM_W'(out_row_reg) + DIM_W'(1)) >= h_reg;
        rd_addr   = is_drain ? out_col_reg : in_col_reg;
        v1_next   = accept && (!is_drain || drain_reg);
        hit_next  = fire1 && s1_pix_reg && (s1_addr_reg == rd_addr);

        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        in_cnt_next  = in_cnt_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        drain_next   = drain_reg;

        if (accept && (!is_drain || drain_reg)) begin
            out_col_next = ocol;
            out_row_next = orow;
            if (!is_drain) begin
                drain_next = 1'b0;
            end
            if (emit) begin
                if (frame_end) begin
                    out_col_next = '0;
                    out_row_next = '0;
                    drain_next   = 1'b0;
                end else if (last_col) begin
                    out_col_next = '0;
                    out_row_next = orow + ROW_W'(1);
                end else begin
                    out_col_next = ocol + COL_W'(1);
                end
            end
        end

        if (accept && !is_drain) begin
            if ((DIM_W'(in_col_reg) + DIM_W'(1)) >= w_reg) begin
                in_col_next = '0;
                if ((DIM_W'(in_row_reg) + DIM_W'(1)) >= h_reg) begin
                    in_row_next = '0;
                    in_cnt_next = '0;
                    drain_next  = 1'b1;
                end else begin
                    in_row_next = in_row_reg + ROW_W'(1);
                    in_cnt_next = in_cnt_reg + CNT_W'(1);
                end
            end else begin
                in_col_next = in_col_reg + COL_W'(1);
                in_cnt_next = in_cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_reg        <= RESET_WIDTH;
            h_reg        <= RESET_HEIGHT;
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            in_cnt_reg   <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            drain_reg    <= 1'b0;
            v1_reg       <= 1'b0;
            window_reg   <= '0;
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_FRAME_WIDTH: begin
                        w_reg <= eff_dim(cfg_data, DIM_W'(MAX_WIDTH));
                    end
                    CFG_FRAME_HEIGHT: begin
                        h_reg <= eff_dim(cfg_data, DIM_W'(MAX_HEIGHT));
                    end
                    default: begin
                    end
                endcase
            end
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            in_cnt_reg  <= in_cnt_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            drain_reg   <= drain_next;
            if (s_tready) begin
                v1_reg <= v1_next;
            end
            if (fire1 && s1_pix_reg) begin
                window_reg <= window_next;
            end
            if (clr_busy_reg) begin
                clr_addr_reg <= clr_addr_reg + COL_W'(1);
                if (clr_addr_reg == COL_W'(MAX_WIDTH - 1)) begin
                    clr_busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_pix_reg  <= !is_drain;
            s1_p_reg    <= s_tdata;
            s1_emit_reg <= emit;
            s1_int_reg  <= interior;
            s1_end_reg  <= frame_end;
            s1_mem_reg  <= mem_src;
            s1_addr_reg <= rd_addr;
            fwd_hit_reg <= hit_next;
            fwd_up_reg  <= lo_eff;
            fwd_lo_reg  <= s1_p_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            upper_mem[mem_wa] <= up_wd;
            lower_mem[mem_wa] <= lo_wd;
        end
        if (accept) begin
            up_rd_reg <= upper_mem[rd_addr];
            lo_rd_reg <= lower_mem[rd_addr];
        end
    end

    mf3_median u_median (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (med_valid),
        .in_ready (med_ready),
        .in_data  (med_in),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_pixel  (m_tdata),
        .m_last   (m_tlast)
    );

endmodule

// ===== src/mf3_checker.sv =====
// ----------------------------------------------------------------------------
// mf3_checker
// Port-level checks of the median filter, bound to the top level.
// ----------------------------------------------------------------------------
module mf3_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_tready,
    input logic          m_tvalid,
    input logic          m_tready,
    input mf3_pkg::pix_t m_tdata,
    input logic          m_tlast
);

    // a stalled result transfer holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output changed");

    // reset empties the pipeline
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    // line memory clearing blocks input after reset
    assert property (@(posedge aclk)
        !aresetn ##1 aresetn |-> !s_tready)
        else $error("input ready during memory clear");

endmodule

bind median_filter_3x3_unit mf3_checker u_checker (.*);

// ===== tb/sv/tb_median_filter_3x3_unit.sv =====
// ----------------------------------------------------------------------------
// tb_median_filter_3x3_unit
// Self-checking testbench for the 3x3 median filter unit.
// ----------------------------------------------------------------------------
// A scoreboard object carries its own line stores, window and raster counters.
// From these it predicts every output pixel and its end-of-frame flag for each
// input transfer, and checks each output transfer against the oldest
// prediction. The stimulus opens with a few directed frames: extreme pixels,
// drain ticks with nothing owed, a pixel arriving while draining, zero and
// tiny sizes. Two oversized frames follow. After them come random phases
// that resize the frame and send whole frames with their drain ticks, cut
// frames short, drop owed pixels, or send noise. Both stream sides idle at
// random.
// ----------------------------------------------------------------------------
module tb_median_filter_3x3_unit;
    import mf3_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;
    localparam logic MODE_PIXEL   = 1'b0;
    localparam logic MODE_DRAIN   = 1'b1;
    localparam int   IDLE_LIMIT   = 5000;
    localparam int   RANDOM_ITEMS = 900;
    localparam int   SETTLE_CYCLES = 8;

    typedef struct packed {
        pix_t value;
        logic frame_end;
    } out_pixel_t;

    class filter_scoreboard;
        logic [DIM_W-1:0] width_reg;
        logic [DIM_W-1:0] height_reg;
        pix_t upper_line [MAX_WIDTH];
        pix_t lower_line [MAX_WIDTH];
        pix_t window [WIN_SIZE];
        int unsigned in_row, in_col, in_count, out_row, out_col;
        bit draining;
        out_pixel_t owed_pixels [$];
        int errors, inputs, ignored, outputs, writes;

        function new();
            width_reg  = 640;
            height_reg = 480;
            foreach (upper_line[i]) begin
                upper_line[i] = '0;
                lower_line[i] = '0;
            end
            foreach (window[i]) window[i] = '0;
            in_row = 0; in_col = 0; in_count = 0;
            out_row = 0; out_col = 0;
            draining = 0;
            errors = 0; inputs = 0; ignored = 0; outputs = 0; writes = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
            writes++;
            if (idx == REG_FRAME_WIDTH) width_reg = val;
            else height_reg = val;
        endfunction

        function int unsigned clamp_dim(logic [DIM_W-1:0] v, int unsigned lim);
            if (v == 0) return 1;
            if (v > lim) return lim;
            return v;
        endfunction

        function int unsigned cur_width();
            return clamp_dim(width_reg, MAX_WIDTH);
        endfunction

        function int unsigned cur_height();
            return clamp_dim(height_reg, MAX_HEIGHT);
        endfunction

        // raster steps from (row, col) up to and including the last pixel
        function int unsigned steps_to_end(int unsigned row, int unsigned col);
            int unsigned n, w, h;
            w = cur_width();
            h = cur_height();
            n = 0;
            forever begin
                n++;
                if (col + 1 >= w) begin
                    col = 0;
                    if (row + 1 >= h) break;
                    row++;
                end else begin
                    col++;
                end
            end
            return n;
        endfunction

        function int unsigned pixels_to_frame_end();
            return steps_to_end(in_row, in_col);
        endfunction

        function int unsigned owed_count();
            return draining ? steps_to_end(out_row, out_col) : 0;
        endfunction

        function pix_t median_of_window();
            pix_t v [WIN_SIZE];
            pix_t t;
            int lo;
            v = window;
            for (int a = 0; a < 5; a++) begin
                lo = a;
                for (int b = a + 1; b < WIN_SIZE; b++)
                    if (v[b] < v[lo]) lo = b;
                t = v[a];
                v[a] = v[lo];
                v[lo] = t;
            end
            return v[4];
        endfunction

        function void emit(pix_t value);
            out_pixel_t e;
            bit last_col, last_row;
            last_col = out_col + 1 >= cur_width();
            last_row = out_row + 1 >= cur_height();
            e.value = value;
            e.frame_end = last_col && last_row;
            owed_pixels.push_back(e);
            if (e.frame_end) begin
                out_row = 0;
                out_col = 0;
                draining = 0;
            end else if (last_col) begin
                out_col = 0;
                out_row++;
            end else begin
                out_col++;
            end
        endfunction

        function void apply_input(logic mode, pix_t pix);
            int unsigned w, h, c;
            pix_t up, lo, orig;
            bit interior;
            w = cur_width();
            h = cur_height();
            inputs++;
            if (mode == MODE_DRAIN) begin
                if (!draining) begin
                    ignored++;
                    return;
                end
                if (out_row + 1 >= h) orig = (out_col < MAX_WIDTH) ? lower_line[out_col] : '0;
                else orig = window[5];
                emit(orig);
                return;
            end
            // a pixel while draining drops the owed outputs
            if (draining) begin
                draining = 0;
                out_row = 0;
                out_col = 0;
            end
            c = (in_col < MAX_WIDTH) ? in_col : MAX_WIDTH - 1;
            up = upper_line[c];
            lo = lower_line[c];
            orig = window[5];
            for (int r = 0; r < 3; r++) begin
                window[r*3]   = window[r*3+1];
                window[r*3+1] = window[r*3+2];
            end
            window[2] = up;
            window[5] = lo;
            window[8] = pix;
            upper_line[c] = lo;
            lower_line[c] = pix;
            if (in_count >= w + 1) begin
                interior = w >= 3 && h >= 3 && out_row >= 1 && out_row + 2 <= h
                           && out_col >= 1 && out_col + 2 <= w;
                emit(interior ? median_of_window() : orig);
            end
            if (in_col + 1 >= w) begin
                in_col = 0;
                if (in_row + 1 >= h) begin
                    in_row = 0;
                    in_count = 0;
                    draining = 1;
                    return;
                end
                in_row++;
            end else begin
                in_col++;
            end
            in_count++;
        endfunction

        task report_mismatch(string msg);
            if (errors < 100) $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_output(pix_t got_pixel, logic got_end);
            out_pixel_t want;
            outputs++;
            if (owed_pixels.size() == 0) begin
                report_mismatch($sformatf("output %0d: pixel %0d with nothing expected",
                                          outputs, got_pixel));
                return;
            end
            want = owed_pixels.pop_front();
            if (got_pixel !== want.value)
                report_mismatch($sformatf("output %0d: pixel_out %0d, expected %0d",
                                          outputs, got_pixel, want.value));
            if (got_end !== want.frame_end)
                report_mismatch($sformatf("output %0d: frame_end %0b, expected %0b",
                                          outputs, got_end, want.frame_end));
        endtask
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DIM_W-1:0]     cfg_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    pix_t                 s_tdata = '0;
    logic                 s_tuser = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    pix_t                 m_tdata;
    logic                 m_tlast;

    filter_scoreboard sb = new();
    bit steady = 1'b0;
    int ready_hold = 0;
    int idle_cycles = 0;

    median_filter_3x3_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #5 aclk = ~aclk;

    function automatic int gap_len();
        return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    endfunction

    function automatic pix_t rand_pixel();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return 8'h00;
        if (r < 16) return 8'hff;
        return $urandom_range(0, 255);
    endfunction

    function automatic logic [DIM_W-1:0] extreme_dim();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 1024;
            2: return 1025;
            default: return 2047;
        endcase
    endfunction

    // sink side: random stalls on m_tready
    always @(negedge aclk) begin
        if (ready_hold > 0) begin
            ready_hold--;
        end else if (steady || $urandom_range(0, 3) != 0) begin
            m_tready <= 1'b1;
            ready_hold = $urandom_range(0, 8);
        end else begin
            m_tready <= 1'b0;
            ready_hold = gap_len() - 1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_output(m_tdata, m_tlast);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", idle_cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_item(logic mode, pix_t pix);
        int gap;
        gap = (!steady && $urandom_range(0, 99) < 30) ? gap_len() : 0;
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tuser  <= mode;
        do @(posedge aclk); while (!s_tready);
        sb.apply_input(mode, pix);
    endtask

    task automatic send_pixels(int unsigned n);
        repeat (n) send_item(MODE_PIXEL, rand_pixel());
    endtask

    task automatic send_drains(int unsigned n);
        repeat (n) send_item(MODE_DRAIN, $urandom_range(0, 255));
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_register(idx, val);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // stop sending, let every owed pixel out and the pipeline empty
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.owed_pixels.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic run_sequence();
        int unsigned rem, owed, kind;
        rem  = sb.pixels_to_frame_end();
        kind = $urandom_range(0, 9);
        if (kind < 7 && rem <= 64) begin
            send_pixels(rem);
            owed = sb.owed_count();
            if (kind < 5) send_drains(owed + $urandom_range(0, 2));
            else if (owed > 0) send_drains($urandom_range(0, owed - 1));
        end else if (kind < 9) begin
            send_pixels($urandom_range(1, (rem < 40) ? rem : 40));
        end else begin
            repeat ($urandom_range(1, 10)) send_item($urandom_range(0, 1), rand_pixel());
        end
    endtask

    initial begin
        pix_t corner_pattern [WIN_SIZE];
        int unsigned base_items, r;
        logic [DIM_W-1:0] w, h;
        corner_pattern = '{8'h00, 8'hff, 8'h00, 8'hff, 8'h80, 8'hff, 8'h00, 8'hff, 8'h00};
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // 3x3 frame with extremes, drain ticks with nothing owed on either side
        write_register(REG_FRAME_WIDTH, 3);
        write_register(REG_FRAME_HEIGHT, 3);
        send_item(MODE_DRAIN, 8'hff);
        foreach (corner_pattern[i]) send_item(MODE_PIXEL, corner_pattern[i]);
        send_drains(sb.owed_count());
        send_item(MODE_DRAIN, 8'h00);

        // zero size acts as 1x1, second pixel lands while draining
        settle();
        write_register(REG_FRAME_WIDTH, 0);
        write_register(REG_FRAME_HEIGHT, 0);
        send_item(MODE_PIXEL, 8'hff);
        send_item(MODE_PIXEL, 8'h00);
        send_drains(2);

        // small frame, cut short by a new frame, then resized mid-frame below
        settle();
        write_register(REG_FRAME_WIDTH, 2);
        write_register(REG_FRAME_HEIGHT, 2);
        send_pixels(4);
        send_drains(1);
        send_pixels(2);

        // oversized width, then oversized height
        settle();
        write_register(REG_FRAME_WIDTH, 2047);
        write_register(REG_FRAME_HEIGHT, 1);
        send_pixels(sb.pixels_to_frame_end());
        send_drains(sb.owed_count());
        settle();
        write_register(REG_FRAME_WIDTH, 1);
        write_register(REG_FRAME_HEIGHT, 2047);
        send_pixels(sb.pixels_to_frame_end());
        send_drains(sb.owed_count());

        base_items = sb.inputs - sb.ignored;
        while (sb.inputs - sb.ignored < base_items + RANDOM_ITEMS) begin
            settle();
            r = $urandom_range(0, 19);
            if (r == 0) begin
                w = extreme_dim();
                h = $urandom_range(1, 4);
            end else if (r == 1) begin
                w = $urandom_range(1, 3);
                h = extreme_dim();
            end else begin
                w = $urandom_range(1, 9);
                h = $urandom_range(1, 6);
            end
            if ($urandom_range(0, 4) != 0) write_register(REG_FRAME_WIDTH, w);
            if ($urandom_range(0, 4) != 0) write_register(REG_FRAME_HEIGHT, h);
            steady = ($urandom_range(0, 5) == 0);
            repeat ($urandom_range(1, 4)) run_sequence();
        end
        steady = 1'b0;

        settle();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("covered %0d input transfers (%0d drain ticks with nothing owed), %0d output pixels",
                 sb.inputs, sb.ignored, sb.outputs);
        $display("and %0d size writes, frames from 1x1 to 1024 long, resized and restarted mid-frame",
                 sb.writes);
        if (sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
